>>> rtl/egcd_pkg.sv
// egcd_pkg: shared types, program addresses and the control store of the
// extended gcd sequencer. No dependencies; used by egcd_seq and extended_gcd_bezout.
`timescale 1ns / 1ps

package egcd_pkg;

	// program counter of the sequencer
	typedef logic [2:0] pc_t;

	// datapath operation selected by one control word
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_NOP,
		OP_ALIGN,
		OP_SUB,
		OP_SWAP,
		OP_DONE
	} op_t;

	// jump condition selected by one control word
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NOT_START,
		C_D_ZERO,
		C_FITS,
		C_K_NONZERO
	} cond_t;

	// one word of the control store
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic start;
		logic d_zero;
		logic fits;
		logic k_nonzero;
	} status_t;

	// program addresses
	localparam pc_t PC_IDLE  = 3'd0;
	localparam pc_t PC_CHECK = 3'd1;
	localparam pc_t PC_ALIGN = 3'd2;
	localparam pc_t PC_SUB   = 3'd3;
	localparam pc_t PC_SWAP  = 3'd4;
	localparam pc_t PC_DONE  = 3'd5;

	// control store: jump to target when the condition holds, else fall through
	function automatic ctrl_t rom_word(input pc_t addr);
		ctrl_t w;
		case (addr)
			PC_IDLE:  w = '{op: OP_LOAD,  cond: C_NOT_START, target: PC_IDLE};
			PC_CHECK: w = '{op: OP_NOP,   cond: C_D_ZERO,    target: PC_DONE};
			PC_ALIGN: w = '{op: OP_ALIGN, cond: C_FITS,      target: PC_ALIGN};
			PC_SUB:   w = '{op: OP_SUB,   cond: C_K_NONZERO, target: PC_SUB};
			PC_SWAP:  w = '{op: OP_SWAP,  cond: C_ALWAYS,    target: PC_CHECK};
			PC_DONE:  w = '{op: OP_DONE,  cond: C_ALWAYS,    target: PC_IDLE};
			default:  w = '{op: OP_NOP,   cond: C_ALWAYS,    target: PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> rtl/egcd_seq.sv
// egcd_seq: microcode sequencer with program counter and conditional jumps.
// Depends on egcd_pkg for the control store, control word and status types.
`timescale 1ns / 1ps

module egcd_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  egcd_pkg::status_t status,
	output egcd_pkg::ctrl_t   ctrl,
	output logic             busy
);

	egcd_pkg::pc_t pc_q;
	egcd_pkg::pc_t pc_next;
	logic          take;

	// fetch the current control word
	assign ctrl = egcd_pkg::rom_word(pc_q);
	assign busy = (pc_q != egcd_pkg::PC_IDLE);

	// jump condition select
	always_comb begin
		case (ctrl.cond)
			egcd_pkg::C_ALWAYS:    take = 1'b1;
			egcd_pkg::C_NOT_START: take = !status.start;
			egcd_pkg::C_D_ZERO:    take = status.d_zero;
			egcd_pkg::C_FITS:      take = status.fits;
			egcd_pkg::C_K_NONZERO: take = status.k_nonzero;
			default:               take = 1'b1;
		endcase
	end

	// next program address
	always_comb begin
		if (take) begin
			pc_next = ctrl.target;
		end else begin
			pc_next = pc_q + egcd_pkg::pc_t'(1);
		end
	end

	// program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= egcd_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

>>> rtl/extended_gcd_bezout.sv
// extended_gcd_bezout: top level, signed extended gcd with Bezout coefficients.
// Depends on egcd_pkg and egcd_seq (microcode sequencer).
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; the result appears
// on gcd_value, coef_x, coef_y and both_zero_error for exactly one cycle with
// done high, and the receiver cannot stall it. One operand pair is worked at a
// time. Each Euclid step is a zero check, divisor alignment, shift-subtract
// (with the Bezout coefficients updated alongside) and a swap; a final zero
// check ends the run, and then the result is registered. All steps share the
// one shift-subtract datapath.
// Coefficients are produced modulo 2^WIDTH; the most negative operand is
// taken as magnitude 2^(WIDTH-1) and the outputs wrap to their widths.

module extended_gcd_bezout #(
	parameter int WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [WIDTH-1:0] operand_a,
	input  logic signed [WIDTH-1:0] operand_b,
	output logic                    done,
	output logic        [WIDTH-2:0] gcd_value,
	output logic signed [WIDTH-1:0] coef_x,
	output logic signed [WIDTH-1:0] coef_y,
	output logic                    both_zero_error
);

	localparam int KW = $clog2(WIDTH + 1);

	egcd_pkg::ctrl_t   ctrl;
	egcd_pkg::status_t status;

	// working registers: divisor d, dividend/remainder n and their coefficients
	logic [WIDTH-1:0] d_q, n_q;
	logic [WIDTH-1:0] sa_q, ta_q, sb_q, tb_q;
	logic [KW-1:0]    k_q;
	logic             neg_a_q, neg_b_q, zero_q;
	logic             done_q;
	logic [WIDTH-2:0] gcd_q;
	logic [WIDTH-1:0] x_q, y_q;
	logic             err_q;

	logic [WIDTH-1:0] a_bits, b_bits, a_mag, b_mag;
	logic [KW-1:0]    k_inc;
	logic [WIDTH:0]   d_wide;
	logic [WIDTH-1:0] d_sh, sa_sh, ta_sh;
	logic             ge;
	logic [WIDTH-1:0] x_val, y_val;

	// operand magnitudes
	assign a_bits = operand_a;
	assign b_bits = operand_b;
	assign a_mag  = a_bits[WIDTH-1] ? ({WIDTH{1'b0}} - a_bits) : a_bits;
	assign b_mag  = b_bits[WIDTH-1] ? ({WIDTH{1'b0}} - b_bits) : b_bits;

	// alignment test: can the divisor be shifted one more place
	assign k_inc  = k_q + KW'(1);
	assign d_wide = {1'b0, d_q} << k_inc;

	// shifted divisor and coefficients for one quotient bit
	assign d_sh  = d_q << k_q;
	assign sa_sh = sa_q << k_q;
	assign ta_sh = ta_q << k_q;
	assign ge    = (n_q >= d_sh);

	// sign correction of the final coefficients
	assign x_val = neg_a_q ? ({WIDTH{1'b0}} - sb_q) : sb_q;
	assign y_val = neg_b_q ? ({WIDTH{1'b0}} - tb_q) : tb_q;

	// status into the sequencer
	assign status.start     = start;
	assign status.d_zero    = (d_q == '0);
	assign status.fits      = (d_wide <= {1'b0, n_q});
	assign status.k_nonzero = (k_q != '0);

	egcd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// datapath driven by the control word
	always_ff @(posedge clk) begin
		case (ctrl.op)
			egcd_pkg::OP_LOAD: begin
				d_q     <= a_mag;
				n_q     <= b_mag;
				sa_q    <= WIDTH'(1);
				ta_q    <= '0;
				sb_q    <= '0;
				tb_q    <= WIDTH'(1);
				k_q     <= '0;
				neg_a_q <= a_bits[WIDTH-1];
				neg_b_q <= b_bits[WIDTH-1];
				zero_q  <= (a_mag == '0) && (b_mag == '0);
			end
			egcd_pkg::OP_ALIGN: begin
				if (status.fits) begin
					k_q <= k_inc;
				end
			end
			egcd_pkg::OP_SUB: begin
				if (ge) begin
					n_q  <= n_q - d_sh;
					sb_q <= sb_q - sa_sh;
					tb_q <= tb_q - ta_sh;
				end
				if (status.k_nonzero) begin
					k_q <= k_q - KW'(1);
				end
			end
			egcd_pkg::OP_SWAP: begin
				d_q  <= n_q;
				n_q  <= d_q;
				sa_q <= sb_q;
				sb_q <= sa_q;
				ta_q <= tb_q;
				tb_q <= ta_q;
				k_q  <= '0;
			end
			egcd_pkg::OP_DONE: begin
				gcd_q <= zero_q ? '0 : n_q[WIDTH-2:0];
				x_q   <= zero_q ? '0 : x_val;
				y_q   <= zero_q ? '0 : y_val;
				err_q <= zero_q;
			end
			default: begin
			end
		endcase
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == egcd_pkg::OP_DONE);
		end
	end

	assign done            = done_q;
	assign gcd_value       = gcd_q;
	assign coef_x          = x_q;
	assign coef_y          = y_q;
	assign both_zero_error = err_q;

`ifndef SYNTHESIS
	// a result follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	// the block is idle again when the result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while the result strobe is high");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but block not busy");

	// the error result carries zero fields
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && both_zero_error) |-> (gcd_value == '0 && coef_x == '0 && coef_y == '0))
		else $error("error result with nonzero fields");
`endif

endmodule
